@@ sv/cfsp_pkg.sv @@
package cfsp_pkg;

   localparam int COORD_WIDTH     = 24;
   localparam int OUT_WIDTH       = 32;
   localparam int FACE_WIDTH      = 3;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam int FRAC_BITS = 16;
   localparam int ONE_Q16   = 65536;

   // magnitude of a Q2.16 value in [0, 1]
   localparam int MAG_W  = FRAC_BITS + 1;
   // signed Q2.16 value in [-1, 1]
   localparam int N_W    = FRAC_BITS + 2;
   localparam int REM_W  = COORD_WIDTH + 1;
   localparam int R_W    = COORD_WIDTH + 2;
   localparam int ROOT_W = MAG_W;
   localparam int SREM_W = ROOT_W + 3;
   localparam int RAD_W  = 2 * ROOT_W;

   // floor(v / 3) = (v * RECIP3) >> RECIP3_SHIFT, exact for v < 2^17
   localparam int RECIP3_W     = 16;
   localparam int RECIP3_SHIFT = 17;
   localparam logic [RECIP3_W-1:0] RECIP3 = RECIP3_W'(43691);
   localparam int D3_W = MAG_W + RECIP3_W - RECIP3_SHIFT;

   localparam logic [COORD_WIDTH-1:0] FACE_SIZE_RESET     = COORD_WIDTH'(65536);
   localparam logic [COORD_WIDTH-1:0] SPHERE_RADIUS_RESET = COORD_WIDTH'(65536);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FACE_SIZE     = 1'b0,
      CSR_SPHERE_RADIUS = 1'b1
   } csr_index_type;

   typedef enum logic [FACE_WIDTH-1:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0]        coord_u;
      logic [COORD_WIDTH-1:0]        coord_v;
      logic signed [COORD_WIDTH-1:0] height;
      logic [FACE_WIDTH-1:0]         face;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] sphere_x;
      logic signed [OUT_WIDTH-1:0] sphere_y;
      logic signed [OUT_WIDTH-1:0] sphere_z;
   } rsp_type;

   typedef struct packed {
      logic                 neg;
      logic                 ge;
      logic                 zero;
      logic [REM_W-1:0]     rem;
      logic [FRAC_BITS-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [SREM_W-1:0] rem;
      logic [ROOT_W-1:0] root;
   } sqrt_lane_type;

endpackage

@@ sv/cfsp_div_step.sv @@
module cfsp_div_step (
   input  cfsp_pkg::div_lane_type               src,
   input  logic [cfsp_pkg::COORD_WIDTH-1:0]     divisor,
   output cfsp_pkg::div_lane_type               dst
);

   logic [cfsp_pkg::REM_W-1:0] shifted;
   logic [cfsp_pkg::REM_W-1:0] dvs;
   logic                       fit;

   assign shifted = {src.rem[cfsp_pkg::REM_W-2:0], 1'b0};
   assign dvs     = {1'b0, divisor};
   assign fit     = shifted >= dvs;

   always_comb begin
      dst     = src;
      dst.rem = fit ? shifted - dvs : shifted;
      dst.quo = {src.quo[cfsp_pkg::FRAC_BITS-2:0], fit};
   end

endmodule

@@ sv/cfsp_sqrt_step.sv @@
module cfsp_sqrt_step (
   input  cfsp_pkg::sqrt_lane_type src,
   output cfsp_pkg::sqrt_lane_type dst
);

   logic [cfsp_pkg::SREM_W-1:0] shifted;
   logic [cfsp_pkg::SREM_W-1:0] trial;
   logic                        fit;

   assign shifted = {src.rem[cfsp_pkg::SREM_W-3:0],
                     src.rad[cfsp_pkg::RAD_W-1:cfsp_pkg::RAD_W-2]};
   assign trial   = {{(cfsp_pkg::SREM_W-cfsp_pkg::ROOT_W-2){1'b0}}, src.root, 2'b01};
   assign fit     = shifted >= trial;

   always_comb begin
      dst.rad  = {src.rad[cfsp_pkg::RAD_W-3:0], 2'b00};
      dst.rem  = fit ? shifted - trial : shifted;
      dst.root = {src.root[cfsp_pkg::ROOT_W-2:0], fit};
   end

endmodule

@@ sv/cube_face_to_sphere_point.sv @@
// Pipeline: 43 register stages: input offsets, 16 divide steps, normalize, square,
// product, divide by three, warp term, 17 square-root steps, two multiply stages,
// saturation, output register. Throughput: one transaction per cycle; a two-entry output
// buffer stalls req_ready only once both entries hold results. Reset is synchronous and
// active high: it empties the pipeline and sets face_size and sphere_radius to 1.0.
module cube_face_to_sphere_point (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  cfsp_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cfsp_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [cfsp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cfsp_pkg::COORD_WIDTH-1:0]     csr_wdata
);

   localparam int W          = cfsp_pkg::COORD_WIDTH;
   localparam int MAG_W      = cfsp_pkg::MAG_W;
   localparam int N_W        = cfsp_pkg::N_W;
   localparam int R_W        = cfsp_pkg::R_W;
   localparam int FB         = cfsp_pkg::FRAC_BITS;
   localparam int DIV_STEPS  = cfsp_pkg::FRAC_BITS;
   localparam int SQRT_STEPS = cfsp_pkg::ROOT_W;
   localparam int ST_N       = DIV_STEPS + 1;
   localparam int ST_Q       = ST_N + 1;
   localparam int ST_P       = ST_Q + 1;
   localparam int ST_D3      = ST_P + 1;
   localparam int ST_T       = ST_D3 + 1;
   localparam int ST_M       = ST_T + SQRT_STEPS + 1;
   localparam int ST_R       = ST_M + 1;
   localparam int ST_O       = ST_R + 1;
   localparam int NSTG       = ST_O + 1;
   localparam int PR_W       = W + 1 + MAG_W;
   localparam int OM_W       = PR_W - FB;

   typedef struct packed {
      cfsp_pkg::div_lane_type              u;
      cfsp_pkg::div_lane_type              v;
      logic [cfsp_pkg::FACE_WIDTH-1:0]     face;
      logic signed [R_W-1:0]               radius;
   } div_stage_type;

   typedef struct packed {
      logic [2:0][N_W-1:0]   p;
      logic signed [R_W-1:0] radius;
   } xyz_stage_type;

   typedef struct packed {
      logic [2:0]              neg;
      logic [2:0][MAG_W-1:0]   mag;
      logic [2:0][MAG_W-1:0]   sq;
      logic signed [R_W-1:0]   radius;
   } square_stage_type;

   typedef struct packed {
      logic [2:0]              neg;
      logic [2:0][MAG_W-1:0]   mag;
      logic [2:0][MAG_W-1:0]   prod;
      logic [2:0][MAG_W-1:0]   hsum;
      logic signed [R_W-1:0]   radius;
   } pair_stage_type;

   typedef struct packed {
      logic [2:0]                        neg;
      logic [2:0][MAG_W-1:0]             mag;
      logic [2:0][cfsp_pkg::D3_W-1:0]    d3;
      logic [2:0][MAG_W-1:0]             hsum;
      logic signed [R_W-1:0]             radius;
   } third_stage_type;

   typedef struct packed {
      logic [2:0]                        neg;
      logic [2:0][MAG_W-1:0]             mag;
      cfsp_pkg::sqrt_lane_type [2:0]     lane;
      logic signed [R_W-1:0]             radius;
   } root_stage_type;

   typedef struct packed {
      logic [2:0]              neg;
      logic [2:0][MAG_W-1:0]   wmag;
      logic                    rneg;
      logic [W:0]              rmag;
   } wmul_stage_type;

   typedef struct packed {
      logic [2:0]             neg;
      logic [2:0][PR_W-1:0]   prod;
   } rmul_stage_type;

   function automatic cfsp_pkg::div_lane_type lane_init(input logic [W-1:0] c,
                                                        input logic [W-1:0] fs);
      logic [W+1:0]           diff;
      logic [W+1:0]           mag;
      cfsp_pkg::div_lane_type l;
      diff   = {1'b0, c, 1'b0} - {2'b00, fs};
      mag    = diff[W+1] ? (~diff + 1'b1) : diff;
      l.neg  = diff[W+1];
      l.rem  = mag[W:0];
      l.ge   = mag[W:0] >= {1'b0, fs};
      l.zero = (c == '0);
      l.quo  = '0;
      return l;
   endfunction

   function automatic logic [N_W-1:0] norm(input cfsp_pkg::div_lane_type l,
                                           input logic [W-1:0] fs);
      logic [N_W-1:0] mag;
      if (fs == '0) begin
         mag = l.zero ? '0 : N_W'(cfsp_pkg::ONE_Q16);
      end else if (l.ge) begin
         mag = N_W'(cfsp_pkg::ONE_Q16);
      end else begin
         mag = {2'b00, l.quo};
      end
      return l.neg ? -mag : mag;
   endfunction

   function automatic logic [cfsp_pkg::OUT_WIDTH-1:0] sat_out(input logic neg,
                                                              input logic [OM_W-1:0] m);
      logic [63:0] m64;
      logic [63:0] nm64;
      m64  = 64'(m);
      nm64 = ~m64 + 64'd1;
      if (neg) begin
         return (m64 > 64'h8000_0000) ? 32'h8000_0000 : nm64[31:0];
      end else begin
         return (m64 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m64[31:0];
      end
   endfunction

   logic [W-1:0]       face_size_ff;
   logic [W-1:0]       sphere_radius_ff;
   logic [NSTG-1:0]    v_ff;
   logic               adv;

   div_stage_type      dv_in [0:DIV_STEPS];
   div_stage_type      dv_ff [0:DIV_STEPS];
   xyz_stage_type      n_in, n_ff;
   square_stage_type   q_in, q_ff;
   pair_stage_type     p_in, p_ff;
   third_stage_type    d3_in, d3_ff;
   root_stage_type     rt_in [0:SQRT_STEPS];
   root_stage_type     rt_ff [0:SQRT_STEPS];
   wmul_stage_type     m_in, m_ff;
   rmul_stage_type     r_in, r_ff;
   cfsp_pkg::rsp_type  o_in, o_ff;
   cfsp_pkg::rsp_type  out_ff, skid_ff;
   logic               out_v_ff, skid_v_ff;
   logic               push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff     <= cfsp_pkg::FACE_SIZE_RESET;
         sphere_radius_ff <= cfsp_pkg::SPHERE_RADIUS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            cfsp_pkg::CSR_FACE_SIZE:     face_size_ff     <= csr_wdata;
            cfsp_pkg::CSR_SPHERE_RADIUS: sphere_radius_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline moves as a whole; it stops only once the skid entry is taken
   assign adv       = !skid_v_ff;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NSTG-2:0], req_valid};
      end
   end

   // stage 0: offsets, magnitudes and radius
   always_comb begin
      dv_in[0].u      = lane_init(req_data.coord_u, face_size_ff);
      dv_in[0].v      = lane_init(req_data.coord_v, face_size_ff);
      dv_in[0].face   = req_data.face;
      dv_in[0].radius = R_W'(signed'({2'b00, sphere_radius_ff})) + R_W'(req_data.height);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0] <= dv_in[0];
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
      cfsp_pkg::div_lane_type u_dst;
      cfsp_pkg::div_lane_type v_dst;

      cfsp_div_step u_div_u (.src(dv_ff[k-1].u), .divisor(face_size_ff), .dst(u_dst));
      cfsp_div_step u_div_v (.src(dv_ff[k-1].v), .divisor(face_size_ff), .dst(v_dst));

      always_comb begin
         dv_in[k]   = dv_ff[k-1];
         dv_in[k].u = u_dst;
         dv_in[k].v = v_dst;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   // normalize and map the face onto the axes
   always_comb begin
      logic [N_W-1:0] a;
      logic [N_W-1:0] b;
      logic [N_W-1:0] one;
      a   = norm(dv_ff[DIV_STEPS].u, face_size_ff);
      b   = norm(dv_ff[DIV_STEPS].v, face_size_ff);
      one = N_W'(cfsp_pkg::ONE_Q16);
      n_in.radius = dv_ff[DIV_STEPS].radius;
      case (dv_ff[DIV_STEPS].face)
         cfsp_pkg::FACE_NEG_X: begin
            n_in.p[0] = -one; n_in.p[1] = -b;  n_in.p[2] = a;
         end
         cfsp_pkg::FACE_POS_Y: begin
            n_in.p[0] = -b;   n_in.p[1] = one; n_in.p[2] = a;
         end
         cfsp_pkg::FACE_NEG_Y: begin
            n_in.p[0] = b;    n_in.p[1] = -one; n_in.p[2] = a;
         end
         cfsp_pkg::FACE_POS_Z: begin
            n_in.p[0] = -a;   n_in.p[1] = -b;  n_in.p[2] = -one;
         end
         cfsp_pkg::FACE_NEG_Z: begin
            n_in.p[0] = a;    n_in.p[1] = -b;  n_in.p[2] = one;
         end
         default: begin
            n_in.p[0] = one;  n_in.p[1] = -b;  n_in.p[2] = -a;
         end
      endcase
   end

   always_comb begin
      logic [N_W-1:0]     absv;
      logic [2*MAG_W-1:0] prod;
      q_in.radius = n_ff.radius;
      for (int a = 0; a < 3; a++) begin
         q_in.neg[a] = n_ff.p[a][N_W-1];
         absv        = n_ff.p[a][N_W-1] ? -n_ff.p[a] : n_ff.p[a];
         q_in.mag[a] = absv[MAG_W-1:0];
         prod        = absv[MAG_W-1:0] * absv[MAG_W-1:0];
         q_in.sq[a]  = prod[MAG_W+FB-1:FB];
      end
   end

   always_comb begin
      int                 qi;
      int                 ri;
      logic [2*MAG_W-1:0] prod;
      p_in.neg    = q_ff.neg;
      p_in.mag    = q_ff.mag;
      p_in.radius = q_ff.radius;
      for (int a = 0; a < 3; a++) begin
         qi = (a == 2) ? 0 : a + 1;
         ri = (a == 0) ? 2 : a - 1;
         prod         = q_ff.sq[qi] * q_ff.sq[ri];
         p_in.prod[a] = prod[MAG_W+FB-1:FB];
         p_in.hsum[a] = {1'b0, q_ff.sq[qi][MAG_W-1:1]} + {1'b0, q_ff.sq[ri][MAG_W-1:1]};
      end
   end

   always_comb begin
      logic [MAG_W+cfsp_pkg::RECIP3_W-1:0] prod;
      d3_in.neg    = p_ff.neg;
      d3_in.mag    = p_ff.mag;
      d3_in.hsum   = p_ff.hsum;
      d3_in.radius = p_ff.radius;
      for (int a = 0; a < 3; a++) begin
         prod        = p_ff.prod[a] * cfsp_pkg::RECIP3;
         d3_in.d3[a] = prod[MAG_W+cfsp_pkg::RECIP3_W-1:cfsp_pkg::RECIP3_SHIFT];
      end
   end

   // warp term t = 1 - q^2/2 - r^2/2 + q^2 r^2 / 3, never negative
   always_comb begin
      logic [MAG_W-1:0] t;
      rt_in[0].neg    = d3_ff.neg;
      rt_in[0].mag    = d3_ff.mag;
      rt_in[0].radius = d3_ff.radius;
      for (int a = 0; a < 3; a++) begin
         t = MAG_W'(cfsp_pkg::ONE_Q16) - d3_ff.hsum[a] + MAG_W'(d3_ff.d3[a]);
         rt_in[0].lane[a].rad  = {1'b0, t, {FB{1'b0}}};
         rt_in[0].lane[a].rem  = '0;
         rt_in[0].lane[a].root = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff     <= n_in;
         q_ff     <= q_in;
         p_ff     <= p_in;
         d3_ff    <= d3_in;
         rt_ff[0] <= rt_in[0];
      end
   end

   for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
      cfsp_pkg::sqrt_lane_type [2:0] dst;

      for (genvar a = 0; a < 3; a++) begin : g_axis
         cfsp_sqrt_step u_sqrt (.src(rt_ff[k-1].lane[a]), .dst(dst[a]));
      end

      always_comb begin
         rt_in[k]      = rt_ff[k-1];
         rt_in[k].lane = dst;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rt_ff[k] <= rt_in[k];
         end
      end
   end

   always_comb begin
      logic [2*MAG_W-1:0] prod;
      logic [R_W-1:0]     rabs;
      m_in.neg  = rt_ff[SQRT_STEPS].neg;
      m_in.rneg = rt_ff[SQRT_STEPS].radius[R_W-1];
      rabs      = m_in.rneg ? -rt_ff[SQRT_STEPS].radius : rt_ff[SQRT_STEPS].radius;
      m_in.rmag = rabs[W:0];
      for (int a = 0; a < 3; a++) begin
         prod         = rt_ff[SQRT_STEPS].mag[a] * rt_ff[SQRT_STEPS].lane[a].root;
         m_in.wmag[a] = prod[MAG_W+FB-1:FB];
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         r_in.neg[a]  = m_ff.neg[a] ^ m_ff.rneg;
         r_in.prod[a] = m_ff.rmag * m_ff.wmag[a];
      end
   end

   always_comb begin
      o_in.sphere_x = sat_out(r_ff.neg[0], r_ff.prod[0][PR_W-1:FB]);
      o_in.sphere_y = sat_out(r_ff.neg[1], r_ff.prod[1][PR_W-1:FB]);
      o_in.sphere_z = sat_out(r_ff.neg[2], r_ff.prod[2][PR_W-1:FB]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff <= m_in;
         r_ff <= r_in;
         o_ff <= o_in;
      end
   end

   // output register with one skid entry
   assign push = adv && v_ff[ST_O];
   assign pop  = out_v_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (pop) begin
         if (skid_v_ff) begin
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= push;
         end
      end else if (push) begin
         if (out_v_ff) begin
            skid_v_ff <= 1'b1;
         end else begin
            out_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_v_ff) begin
         out_ff <= skid_ff;
      end else if (push && (pop || !out_v_ff)) begin
         out_ff <= o_ff;
      end
      if (push && out_v_ff && !pop) begin
         skid_ff <= o_ff;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

`ifndef NO_ASSERTIONS
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (v_ff == '0) && !out_v_ff && !skid_v_ff)
      else $error("pipeline not empty after reset");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry holds a transaction while the output register is empty");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side stalled with an empty output");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_N] |->
         ($signed(n_ff.p[0]) <= $signed(N_W'(cfsp_pkg::ONE_Q16))) &&
         ($signed(n_ff.p[0]) >= -$signed(N_W'(cfsp_pkg::ONE_Q16))) &&
         ($signed(n_ff.p[1]) <= $signed(N_W'(cfsp_pkg::ONE_Q16))) &&
         ($signed(n_ff.p[1]) >= -$signed(N_W'(cfsp_pkg::ONE_Q16))) &&
         ($signed(n_ff.p[2]) <= $signed(N_W'(cfsp_pkg::ONE_Q16))) &&
         ($signed(n_ff.p[2]) >= -$signed(N_W'(cfsp_pkg::ONE_Q16))))
      else $error("normalized coordinate outside [-1, 1]");
`endif

endmodule
